// File: rtl/htr_pkg.sv
package htr_pkg;

    localparam int MAX_TAG_LENGTH_DEFAULT = 4096;
    localparam int MATCH_LENGTH_W = 13;

    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_BTICK  = 8'h60;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_AFTER_LT,
        PH_CLOSE_START,
        PH_CLOSE_NAME,
        PH_CLOSE_WS,
        PH_OPEN_NAME,
        PH_SLOT,
        PH_SLASH,
        PH_ATTR_NAME,
        PH_AFTER_ATTR,
        PH_VALUE_WS,
        PH_QUOTED,
        PH_UNQUOTED
    } phase_t;

    typedef enum logic [1:0] {
        GO_ON,
        GO_REJECT,
        GO_ACCEPT
    } verdict_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT
            || c == CH_FF || c == CH_CR;
    endfunction

    function automatic logic is_tag_char(input logic [7:0] c);
        return is_alpha(c) || is_num(c) || c == CH_DASH;
    endfunction

    function automatic logic is_attr_start(input logic [7:0] c);
        return is_alpha(c) || c == CH_UNDER || c == CH_COLON;
    endfunction

    function automatic logic is_attr_char(input logic [7:0] c);
        return is_alpha(c) || is_num(c) || c == CH_UNDER || c == CH_DOT
            || c == CH_COLON || c == CH_DASH;
    endfunction

    function automatic logic is_unquoted_char(input logic [7:0] c);
        return !is_ws(c) && c != CH_DQUOTE && c != CH_SQUOTE && c != CH_EQ
            && c != CH_LT && c != CH_GT && c != CH_BTICK;
    endfunction

endpackage

// File: rtl/html_tag_recognizer.sv
// Recognizes an inline HTML open or close tag at the start of a byte stream, one byte per
// beat, and returns one result beat per decided candidate: accepted and the tag length in
// bytes (zero when rejected). A beat with first_byte set restarts recognition and drops an
// undecided candidate without a result. The block sustains one byte per cycle while
// in_stall is low: the whole state update for a byte is a single pass through the phase
// logic, and the deciding byte's result is registered. Results go into a two-entry output
// buffer, so the input stalls only when both entries are held by a stalled output.
module html_tag_recognizer #(
    parameter int MAX_TAG_LENGTH = htr_pkg::MAX_TAG_LENGTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         text_byte,
    input  logic                               first_byte,
    input  logic                               end_of_text,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               accepted,
    output logic [htr_pkg::MATCH_LENGTH_W-1:0] match_length
);
    import htr_pkg::*;

    localparam int CW = $clog2(MAX_TAG_LENGTH + 1);

    phase_t          phase_reg, phase_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            quote_reg, quote_next;
    logic            sep_reg, sep_next;

    logic            skid_valid_reg;
    logic            skid_acc_reg;
    logic [MATCH_LENGTH_W-1:0] skid_len_reg;
    logic            out_valid_reg;
    logic            out_acc_reg;
    logic [MATCH_LENGTH_W-1:0] out_len_reg;

    logic            beat;
    verdict_t        verdict;
    logic            res_valid;
    logic            res_acc;
    logic [MATCH_LENGTH_W-1:0] res_len;
    logic [CW+MATCH_LENGTH_W-1:0] count_ext;

    // Advance chain variables.
    phase_t          ph;
    logic            sep_tmp;
    verdict_t        adv;
    phase_t          adv_phase;
    logic            adv_sep;
    logic            adv_quote;

    assign in_stall = skid_valid_reg;
    assign beat     = in_valid && !in_stall;

    // Phase advance for a byte in the middle of a candidate. Phases that end on a byte
    // which is not their own hand that byte on to the following phase.
    always_comb
    begin
        ph        = phase_reg;
        sep_tmp   = sep_reg;
        if (ph == PH_CLOSE_NAME && !is_tag_char(text_byte))
        begin
            ph = PH_CLOSE_WS;
        end
        if (ph == PH_OPEN_NAME && !is_tag_char(text_byte))
        begin
            ph      = PH_SLOT;
            sep_tmp = 1'b0;
        end
        if (ph == PH_ATTR_NAME && !is_attr_char(text_byte))
        begin
            ph      = PH_AFTER_ATTR;
            sep_tmp = 1'b0;
        end
        // An attribute name with no '=' starts the next slot and keeps its separator.
        if (ph == PH_AFTER_ATTR && !is_ws(text_byte) && text_byte != CH_EQ)
        begin
            ph = PH_SLOT;
        end
        if (ph == PH_UNQUOTED && !is_unquoted_char(text_byte))
        begin
            ph      = PH_SLOT;
            sep_tmp = 1'b0;
        end

        adv       = GO_REJECT;
        adv_phase = ph;
        adv_sep   = sep_tmp;
        adv_quote = quote_reg;
        unique case (ph)
            PH_AFTER_LT:
            begin
                if (text_byte == CH_SLASH)
                begin
                    adv       = GO_ON;
                    adv_phase = PH_CLOSE_START;
                end
                else if (is_alpha(text_byte))
                begin
                    adv       = GO_ON;
                    adv_phase = PH_OPEN_NAME;
                end
            end
            PH_CLOSE_START:
            begin
                if (is_alpha(text_byte))
                begin
                    adv       = GO_ON;
                    adv_phase = PH_CLOSE_NAME;
                end
            end
            PH_CLOSE_NAME, PH_OPEN_NAME, PH_ATTR_NAME:
            begin
                adv = GO_ON;
            end
            PH_CLOSE_WS:
            begin
                if (is_ws(text_byte))
                    adv = GO_ON;
                else if (text_byte == CH_GT)
                    adv = GO_ACCEPT;
            end
            PH_SLOT:
            begin
                if (is_ws(text_byte))
                begin
                    adv     = GO_ON;
                    adv_sep = 1'b1;
                end
                else if (text_byte == CH_GT)
                begin
                    adv = GO_ACCEPT;
                end
                else if (text_byte == CH_SLASH)
                begin
                    adv       = GO_ON;
                    adv_phase = PH_SLASH;
                end
                else if (sep_tmp && is_attr_start(text_byte))
                begin
                    adv       = GO_ON;
                    adv_phase = PH_ATTR_NAME;
                end
            end
            PH_SLASH:
            begin
                if (text_byte == CH_GT)
                    adv = GO_ACCEPT;
            end
            PH_AFTER_ATTR:
            begin
                adv = GO_ON;
                if (is_ws(text_byte))
                    adv_sep = 1'b1;
                else
                    adv_phase = PH_VALUE_WS;
            end
            PH_VALUE_WS:
            begin
                if (is_ws(text_byte))
                begin
                    adv = GO_ON;
                end
                else if (text_byte == CH_DQUOTE || text_byte == CH_SQUOTE)
                begin
                    adv       = GO_ON;
                    adv_quote = (text_byte == CH_DQUOTE);
                    adv_phase = PH_QUOTED;
                end
                else if (is_unquoted_char(text_byte))
                begin
                    adv       = GO_ON;
                    adv_phase = PH_UNQUOTED;
                end
            end
            PH_QUOTED:
            begin
                adv = GO_ON;
                if (text_byte == (quote_reg ? CH_DQUOTE : CH_SQUOTE))
                begin
                    adv_phase = PH_SLOT;
                    adv_sep   = 1'b0;
                end
            end
            PH_UNQUOTED:
            begin
                adv = GO_ON;
            end
            default:
            begin
                adv = GO_REJECT;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        quote_next = quote_reg;
        sep_next   = sep_reg;
        verdict    = GO_ON;
        res_valid  = 1'b0;
        if (beat)
        begin
            if (first_byte)
            begin
                quote_next = 1'b0;
                sep_next   = 1'b0;
                count_next = CW'(1);
                phase_next = PH_AFTER_LT;
                verdict    = (text_byte == CH_LT) ? GO_ON : GO_REJECT;
                res_valid  = 1'b1;
            end
            else if (phase_reg != PH_IDLE)
            begin
                res_valid = 1'b1;
                if (count_reg >= CW'(MAX_TAG_LENGTH))
                begin
                    verdict = GO_REJECT;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                    verdict    = adv;
                    phase_next = adv_phase;
                    sep_next   = adv_sep;
                    quote_next = adv_quote;
                end
            end
            if (verdict == GO_ON && end_of_text)
                verdict = GO_REJECT;
            if (verdict == GO_ON)
                res_valid = 1'b0;
            if (res_valid)
                phase_next = PH_IDLE;
        end
    end

    // Result fields.
    always_comb
    begin
        count_ext = {{MATCH_LENGTH_W{1'b0}}, count_next};
        res_acc   = (verdict == GO_ACCEPT);
        res_len   = res_acc ? count_ext[MATCH_LENGTH_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            count_reg      <= '0;
            quote_reg      <= 1'b0;
            sep_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            quote_reg <= quote_next;
            sep_reg   <= sep_next;
            if (!out_valid_reg || !out_stall)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= res_valid;
                end
                else
                begin
                    out_valid_reg <= res_valid;
                end
            end
            else if (res_valid)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_acc_reg  <= skid_acc_reg;
                out_len_reg  <= skid_len_reg;
                skid_acc_reg <= res_acc;
                skid_len_reg <= res_len;
            end
            else
            begin
                out_acc_reg <= res_acc;
                out_len_reg <= res_len;
            end
        end
        else if (res_valid)
        begin
            skid_acc_reg <= res_acc;
            skid_len_reg <= res_len;
        end
    end

    assign out_valid    = out_valid_reg;
    assign accepted     = out_acc_reg;
    assign match_length = out_len_reg;

endmodule

// File: rtl/htr_checker.sv
module htr_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_stall,
    input logic [7:0]                         text_byte,
    input logic                               first_byte,
    input logic                               end_of_text,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic                               accepted,
    input logic [htr_pkg::MATCH_LENGTH_W-1:0] match_length
);
    import htr_pkg::*;

    // A rejected candidate reports no length.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted |-> match_length == '0)
        else $error("rejected beat carries a nonzero length");

    // The shortest tag is three bytes.
    a_accept_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && accepted |-> match_length >= MATCH_LENGTH_W'(3))
        else $error("accepted tag shorter than three bytes");

    // A first byte that is not '<' decides at once.
    a_bad_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && first_byte && text_byte != CH_LT |=> out_valid)
        else $error("no result after a bad first byte");

    // A first byte at the end of text always decides its candidate.
    a_end_decides: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && first_byte && end_of_text |=> out_valid)
        else $error("no result after a single-byte candidate at end of text");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(accepted) && $stable(match_length))
        else $error("stalled result beat changed");

endmodule

bind html_tag_recognizer htr_checker u_htr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .text_byte    (text_byte),
    .first_byte   (first_byte),
    .end_of_text  (end_of_text),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .accepted     (accepted),
    .match_length (match_length)
);

// File: tb/sv/tag_verdict_pkg.sv
package tag_verdict_pkg;
    timeunit 1ns;
    timeprecision 1ps;

    import htr_pkg::*;

    typedef struct {
        logic                      acc;
        logic [MATCH_LENGTH_W-1:0] len;
    } tag_verdict_t;

    function automatic bit letter_byte(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic bit digit_byte(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic bit blank_byte(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT || c == CH_FF
            || c == CH_CR;
    endfunction

    function automatic bit name_byte(logic [7:0] c);
        return letter_byte(c) || digit_byte(c) || c == CH_DASH;
    endfunction

    function automatic bit attr_lead_byte(logic [7:0] c);
        return letter_byte(c) || c == CH_UNDER || c == CH_COLON;
    endfunction

    function automatic bit attr_body_byte(logic [7:0] c);
        return attr_lead_byte(c) || digit_byte(c) || c == CH_DOT || c == CH_DASH;
    endfunction

    function automatic bit bare_value_byte(logic [7:0] c);
        return !blank_byte(c) && c != CH_DQUOTE && c != CH_SQUOTE && c != CH_EQ
            && c != CH_LT && c != CH_GT && c != CH_BTICK;
    endfunction

    class tag_verdict_tracker;
        phase_t                    phase;
        logic [MATCH_LENGTH_W-1:0] count;
        logic                      quote_dq;
        logic                      sep_seen;
        tag_verdict_t              pending_verdicts[$];
        int unsigned               errors;

        function new();
            phase      = PH_IDLE;
            count      = '0;
            quote_dq   = 1'b0;
            sep_seen   = 1'b0;
            errors     = 0;
        endfunction

        // Some phases hand the same byte on to the next phase, hence the loop.
        function verdict_t step_phase(logic [7:0] c);
            verdict_t v;
            bit       again;
            do
            begin
                again = 1'b0;
                v     = GO_ON;
                case (phase)
                    PH_AFTER_LT:
                        if (c == CH_SLASH)
                            phase = PH_CLOSE_START;
                        else if (letter_byte(c))
                            phase = PH_OPEN_NAME;
                        else
                            v = GO_REJECT;
                    PH_CLOSE_START:
                        if (letter_byte(c))
                            phase = PH_CLOSE_NAME;
                        else
                            v = GO_REJECT;
                    PH_CLOSE_NAME:
                        if (!name_byte(c))
                        begin
                            phase = PH_CLOSE_WS;
                            again = 1'b1;
                        end
                    PH_CLOSE_WS:
                        if (!blank_byte(c))
                            v = (c == CH_GT) ? GO_ACCEPT : GO_REJECT;
                    PH_OPEN_NAME:
                        if (!name_byte(c))
                        begin
                            phase    = PH_SLOT;
                            sep_seen = 1'b0;
                            again    = 1'b1;
                        end
                    PH_SLOT:
                        if (blank_byte(c))
                            sep_seen = 1'b1;
                        else if (c == CH_GT)
                            v = GO_ACCEPT;
                        else if (c == CH_SLASH)
                            phase = PH_SLASH;
                        else if (sep_seen && attr_lead_byte(c))
                            phase = PH_ATTR_NAME;
                        else
                            v = GO_REJECT;
                    PH_SLASH:
                        v = (c == CH_GT) ? GO_ACCEPT : GO_REJECT;
                    PH_ATTR_NAME:
                        if (!attr_body_byte(c))
                        begin
                            phase    = PH_AFTER_ATTR;
                            sep_seen = 1'b0;
                            again    = 1'b1;
                        end
                    PH_AFTER_ATTR:
                        if (blank_byte(c))
                            sep_seen = 1'b1;
                        else if (c == CH_EQ)
                            phase = PH_VALUE_WS;
                        else
                        begin
                            // A name without a value: the whitespace seen so far
                            // separates it from the next attribute.
                            phase = PH_SLOT;
                            again = 1'b1;
                        end
                    PH_VALUE_WS:
                        if (!blank_byte(c))
                        begin
                            if (c == CH_DQUOTE || c == CH_SQUOTE)
                            begin
                                quote_dq = (c == CH_DQUOTE);
                                phase    = PH_QUOTED;
                            end
                            else if (bare_value_byte(c))
                                phase = PH_UNQUOTED;
                            else
                                v = GO_REJECT;
                        end
                    PH_QUOTED:
                        if (c == (quote_dq ? CH_DQUOTE : CH_SQUOTE))
                        begin
                            phase    = PH_SLOT;
                            sep_seen = 1'b0;
                        end
                    PH_UNQUOTED:
                        if (!bare_value_byte(c))
                        begin
                            phase    = PH_SLOT;
                            sep_seen = 1'b0;
                            again    = 1'b1;
                        end
                    default:
                        v = GO_REJECT;
                endcase
            end
            while (again);
            return v;
        endfunction

        function void observe_byte(logic [7:0] c, logic first, logic last);
            verdict_t     v;
            tag_verdict_t r;
            if (first)
            begin
                quote_dq = 1'b0;
                sep_seen = 1'b0;
                count    = MATCH_LENGTH_W'(1);
                if (c != CH_LT)
                    v = GO_REJECT;
                else
                begin
                    phase = PH_AFTER_LT;
                    v     = GO_ON;
                end
            end
            else
            begin
                if (phase == PH_IDLE)
                    return;
                if (count >= MAX_TAG_LENGTH_DEFAULT)
                    v = GO_REJECT;
                else
                begin
                    count++;
                    v = step_phase(c);
                end
            end
            if (v == GO_ON && last)
                v = GO_REJECT;
            if (v == GO_ON)
                return;
            r.acc = (v == GO_ACCEPT);
            r.len = (v == GO_ACCEPT) ? count : '0;
            pending_verdicts = {pending_verdicts, r};
            phase = PH_IDLE;
        endfunction

        function void compare_verdict(logic acc, logic [MATCH_LENGTH_W-1:0] len);
            tag_verdict_t want;
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: result beat with none expected, accepted %0d match_length %0d",
                         $time, acc, len);
                errors++;
                return;
            end
            want = pending_verdicts.pop_front();
            if (acc !== want.acc)
            begin
                $display("%0t: accepted expected %0d, actual %0d", $time, want.acc, acc);
                errors++;
            end
            if (len !== want.len)
            begin
                $display("%0t: match_length expected %0d, actual %0d", $time, want.len, len);
                errors++;
            end
        endfunction

        function void flag_leftovers();
            if (pending_verdicts.size() != 0)
            begin
                $display("%0t: %0d result beats missing, oldest accepted %0d length %0d",
                         $time, pending_verdicts.size(), pending_verdicts[0].acc,
                         pending_verdicts[0].len);
                errors++;
            end
        endfunction
    endclass

endpackage

// File: tb/sv/tb_html_tag_recognizer.sv
module tb_html_tag_recognizer;
    timeunit 1ns;
    timeprecision 1ps;

    import htr_pkg::*;
    import tag_verdict_pkg::*;

    localparam int TOTAL_BEATS     = 1850;
    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_LIMIT     = 100000;

    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      in_valid    = 1'b0;
    logic                      in_stall;
    logic [7:0]                text_byte   = 8'h00;
    logic                      first_byte  = 1'b0;
    logic                      end_of_text = 1'b0;
    logic                      out_valid;
    logic                      out_stall   = 1'b0;
    logic                      accepted;
    logic [MATCH_LENGTH_W-1:0] match_length;

    tag_verdict_tracker tracker = new();

    logic [7:0]  cand[$];
    int unsigned burst_left   = 0;
    bit          gaps_on      = 1'b0;
    bit          hold_request = 1'b0;
    int unsigned hold_left    = 0;
    int unsigned stall_mode   = 0;
    int unsigned stall_cycle  = 0;
    int unsigned sent_beats   = 0;

    html_tag_recognizer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .text_byte    (text_byte),
        .first_byte   (first_byte),
        .end_of_text  (end_of_text),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .accepted     (accepted),
        .match_length (match_length)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.compare_verdict(accepted, match_length);
    end

    // Result side: the stall pattern is redrawn at random from four modes; a requested
    // hold-off overrides it for a long stretch.
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_OFF_CYCLES;
            hold_request = 1'b0;
        end
        if (stall_cycle % 96 == 0)
            stall_mode = $urandom_range(0, 3);
        stall_cycle++;
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall = 1'b1;
        end
        else
        begin
            case (stall_mode)
                0:       out_stall = 1'b0;
                1:       out_stall = ($urandom_range(0, 3) == 0);
                2:       out_stall = ($urandom_range(0, 3) != 0);
                default: out_stall = ((stall_cycle % 7) < 3);
            endcase
        end
    end

    function automatic void append_byte(logic [7:0] b);
        cand = {cand, b};
    endfunction

    function automatic logic [7:0] pick_letter();
        logic [7:0] base;
        base = $urandom_range(0, 1) ? 8'h41 : 8'h61;
        return base + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] pick_digit();
        return 8'h30 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_ws();
        case ($urandom_range(0, 5))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            3:       return CH_VT;
            4:       return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] pick_name_char();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return pick_letter();
        if (r < 9)
            return pick_digit();
        return CH_DASH;
    endfunction

    function automatic logic [7:0] pick_attr_lead();
        case ($urandom_range(0, 9))
            8:       return CH_UNDER;
            9:       return CH_COLON;
            default: return pick_letter();
        endcase
    endfunction

    function automatic logic [7:0] pick_attr_body();
        case ($urandom_range(0, 15))
            10, 11:  return pick_digit();
            12:      return CH_UNDER;
            13:      return CH_DOT;
            14:      return CH_COLON;
            15:      return CH_DASH;
            default: return pick_letter();
        endcase
    endfunction

    function automatic logic [7:0] pick_bare();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (!bare_value_byte(b));
        return b;
    endfunction

    function automatic logic [7:0] pick_quoted(logic [7:0] q);
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == q);
        return b;
    endfunction

    function automatic void build_open_tag();
        logic [7:0] q;
        append_byte(CH_LT);
        append_byte(pick_letter());
        repeat ($urandom_range(0, 5)) append_byte(pick_name_char());
        repeat ($urandom_range(0, 3))
        begin
            repeat ($urandom_range(1, 2)) append_byte(pick_ws());
            append_byte(pick_attr_lead());
            repeat ($urandom_range(0, 5)) append_byte(pick_attr_body());
            if ($urandom_range(0, 3) != 0)
            begin
                repeat ($urandom_range(0, 1)) append_byte(pick_ws());
                append_byte(CH_EQ);
                repeat ($urandom_range(0, 1)) append_byte(pick_ws());
                if ($urandom_range(0, 2) != 0)
                begin
                    q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
                    append_byte(q);
                    repeat ($urandom_range(0, 6)) append_byte(pick_quoted(q));
                    append_byte(q);
                end
                else
                    repeat ($urandom_range(1, 6)) append_byte(pick_bare());
            end
        end
        repeat ($urandom_range(0, 1)) append_byte(pick_ws());
        if ($urandom_range(0, 3) == 0)
            append_byte(CH_SLASH);
        append_byte(CH_GT);
    endfunction

    function automatic void build_close_tag();
        append_byte(CH_LT);
        append_byte(CH_SLASH);
        append_byte(pick_letter());
        repeat ($urandom_range(0, 5)) append_byte(pick_name_char());
        repeat ($urandom_range(0, 2)) append_byte(pick_ws());
        append_byte(CH_GT);
    endfunction

    // The sender works in bursts; when gaps are on, valid drops for a gap before a burst.
    task automatic send_beat(logic [7:0] b, logic f, logic e);
        int unsigned gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on)
                gap = $urandom_range(1, 6);
        end
        burst_left--;
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    = 1'b1;
        text_byte   = b;
        first_byte  = f;
        end_of_text = e;
        do
            @(posedge clk);
        while (in_stall);
        sent_beats++;
        tracker.observe_byte(b, f, e);
    endtask

    task automatic send_cand(int eot_at);
        for (int i = 0; i < cand.size(); i++)
            send_beat(cand[i], i == 0, i == eot_at);
        cand.delete();
    endtask

    task automatic send_str(string s, bit eot);
        for (int i = 0; i < s.len(); i++)
            append_byte(s[i]);
        send_cand(eot ? s.len() - 1 : -1);
    endtask

    task automatic drain_results(int unsigned settle, int unsigned limit);
        int unsigned waited;
        waited = 0;
        @(negedge clk);
        in_valid = 1'b0;
        while (tracker.pending_verdicts.size() != 0 && waited < limit)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (settle) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int unsigned kind;
        int unsigned cut;
        int          eot_at;
        bit          held;
        held = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_str("<a>", 1'b0);
        send_str("</a>", 1'b0);
        send_str("</h-1 \t>", 1'b0);
        send_str("<br/>", 1'b0);
        send_str("<a b c>", 1'b0);
        send_str("<a b = 'x>y' c=\"q\" d=v/>", 1'b0);
        send_str("<a b='1'c>", 1'b0);
        send_str("<a\013\014\015\012b>", 1'b0);
        send_str("<a/ >", 1'b0);
        send_str("<a b=>", 1'b0);
        send_str("</>", 1'b0);
        send_str("<1>", 1'b0);
        send_str("<a _x:y.z-1=`>", 1'b0);
        send_beat(8'hFF, 1'b1, 1'b0);
        send_beat(8'h00, 1'b1, 1'b1);
        send_str("<", 1'b1);
        send_str("<a", 1'b1);
        send_str("<i>", 1'b1);
        // Restart in the middle of a candidate, then bytes after the decision.
        send_str("<a b", 1'b0);
        send_str("<i>", 1'b0);
        send_beat(8'h7A, 1'b0, 1'b0);
        send_beat(8'hFF, 1'b0, 1'b1);
        drain_results(SETTLE_CYCLES, DRAIN_LIMIT);

        gaps_on = 1'b1;
        while (sent_beats < TOTAL_BEATS)
        begin
            if (!held && sent_beats >= TOTAL_BEATS / 2)
            begin
                // Long hold-off on results while short tags keep coming.
                held         = 1'b1;
                gaps_on      = 1'b0;
                hold_request = 1'b1;
                repeat (60) send_str("<b>", 1'b0);
                drain_results(SETTLE_CYCLES, DRAIN_LIMIT);
                gaps_on = 1'b1;
            end
            if ($urandom_range(0, 19) == 0)
                gaps_on = !gaps_on;
            if ($urandom_range(0, 149) == 0)
                drain_results(SETTLE_CYCLES, DRAIN_LIMIT);
            kind = $urandom_range(0, 99);
            if (kind < 92)
            begin
                if ($urandom_range(0, 3) == 0)
                    build_close_tag();
                else
                    build_open_tag();
            end
            if (kind < 45)
            begin
                eot_at = ($urandom_range(0, 6) == 0) ? cand.size() - 1 : -1;
                send_cand(eot_at);
            end
            else if (kind < 60)
            begin
                cand[$urandom_range(0, cand.size() - 1)] = 8'($urandom_range(0, 255));
                send_cand(-1);
            end
            else if (kind < 70)
            begin
                cut  = $urandom_range(1, cand.size());
                cand = cand[0:cut-1];
                send_cand(cut - 1);
            end
            else if (kind < 78)
            begin
                // Left unfinished: the next first byte drops it without a result.
                cut  = $urandom_range(1, cand.size() - 1);
                cand = cand[0:cut-1];
                send_cand(-1);
            end
            else if (kind < 92)
            begin
                send_cand(-1);
                repeat ($urandom_range(1, 4))
                    send_beat(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
            end
        end

        drain_results(SETTLE_CYCLES, 20000);
        tracker.flag_leftovers();
        if (tracker.errors == 0)
            $display("html_tag_recognizer verification clean");
        else
            $display("html_tag_recognizer verification failed");
        $finish;
    end

    initial
    begin : watchdog
        #5000000;
        $display("html_tag_recognizer verification failed");
        $finish;
    end

endmodule

// File: html_tag_recognizer.f
rtl/htr_pkg.sv
rtl/html_tag_recognizer.sv
rtl/htr_checker.sv
tb/sv/tag_verdict_pkg.sv
tb/sv/tb_html_tag_recognizer.sv
